// File: sv/pal_pkg.sv
// ----------------------------------------------------------------------------
// pal_pkg
// types, codes and sizes shared by the positional list cells and top level
// ----------------------------------------------------------------------------
package pal_pkg;

	localparam int DEPTH  = 16;
	localparam int IDX_W  = $clog2(DEPTH);
	localparam int CNT_W  = $clog2(DEPTH + 1);
	localparam int DATA_W = 32;
	localparam int POS_W  = 5;
	localparam int CMD_W  = 2;
	localparam int STAT_W = 2;

	localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
	localparam logic [CMD_W-1:0] CMD_DELETE = 2'd1;
	localparam logic [CMD_W-1:0] CMD_READ   = 2'd2;
	localparam logic [CMD_W-1:0] CMD_FIND   = 2'd3;

	localparam logic [STAT_W-1:0] ST_OK       = 2'd0;
	localparam logic [STAT_W-1:0] ST_RANGE    = 2'd1;
	localparam logic [STAT_W-1:0] ST_FULL     = 2'd2;
	localparam logic [STAT_W-1:0] ST_NOTFOUND = 2'd3;

	typedef logic [1:0] cell_op_t;
	localparam cell_op_t CELL_HOLD  = 2'd0;
	localparam cell_op_t CELL_LEFT  = 2'd1;
	localparam cell_op_t CELL_RIGHT = 2'd2;
	localparam cell_op_t CELL_LOAD  = 2'd3;

	typedef struct packed {
		cell_op_t                   op;
		logic signed [DATA_W-1:0]   wdata;
		logic signed [DATA_W-1:0]   key;
	} cell_ctl_t;

	typedef struct packed {
		logic [STAT_W-1:0]          status;
		logic signed [DATA_W-1:0]   read_value;
		logic [POS_W-1:0]           found_position;
		logic [POS_W-1:0]           count_after;
	} res_t;

endpackage

// File: sv/pal_cmd_if.sv
// ----------------------------------------------------------------------------
// pal_cmd_if
// command channel: valid/ready handshake carrying one command word
// ----------------------------------------------------------------------------
interface pal_cmd_if;
	import pal_pkg::*;

	logic                       valid;
	logic                       ready;
	logic [CMD_W-1:0]           cmd;
	logic [POS_W-1:0]           position;
	logic signed [DATA_W-1:0]   item_value;

	modport source (output valid, cmd, position, item_value, input ready);
	modport sink   (input valid, cmd, position, item_value, output ready);

endinterface

// File: sv/pal_res_if.sv
// ----------------------------------------------------------------------------
// pal_res_if
// result channel: valid/ready handshake carrying one result word
// ----------------------------------------------------------------------------
interface pal_res_if;
	import pal_pkg::*;

	logic                       valid;
	logic                       ready;
	logic [STAT_W-1:0]          status;
	logic signed [DATA_W-1:0]   read_value;
	logic [POS_W-1:0]           found_position;
	logic [POS_W-1:0]           count_after;

	modport source (output valid, status, read_value, found_position, count_after,
		input ready);
	modport sink   (input valid, status, read_value, found_position, count_after,
		output ready);

endinterface

// File: sv/pal_cell.sv
// ----------------------------------------------------------------------------
// pal_cell
// one list slot: holds a word, takes it from a neighbour or the new word,
// and compares it against the search key
// ----------------------------------------------------------------------------
module pal_cell (
	input  logic                             clk,
	input  pal_pkg::cell_ctl_t               ctl,
	input  logic signed [pal_pkg::DATA_W-1:0] left_data,
	input  logic signed [pal_pkg::DATA_W-1:0] right_data,
	output logic signed [pal_pkg::DATA_W-1:0] data,
	output logic                             match
);
	import pal_pkg::*;

	logic signed [DATA_W-1:0] data_q;

	always_ff @(posedge clk) begin
		case (ctl.op)
			CELL_LEFT:  data_q <= left_data;
			CELL_RIGHT: data_q <= right_data;
			CELL_LOAD:  data_q <= ctl.wdata;
			default:    data_q <= data_q;
		endcase
	end

	assign data  = data_q;
	assign match = (data_q == ctl.key);

endmodule

// File: sv/positional_array_list.sv
// ----------------------------------------------------------------------------
// positional_array_list
// bounded ordered list of signed words with insert, delete, read and find
// ----------------------------------------------------------------------------
// The list is a row of DEPTH cells, one word each. Every command acts at once:
// insert and delete move all later words one cell along in the same edge, read
// selects one cell, and find compares every cell at once and picks the first
// hit. The result is written to an output register at the edge that accepts
// the command word; a new command is accepted every cycle while that register
// is empty or being taken, so the sustained rate is one command per cycle.
// Invalid positions, a full list and a missing value are reported in status
// and leave the list unchanged.
module positional_array_list (
	input  logic      clk,
	input  logic      arst_n,
	pal_cmd_if.sink   req,
	pal_res_if.source rsp
);
	import pal_pkg::*;

	logic [CNT_W-1:0]          fill_q;
	logic                      rsp_valid_q;
	res_t                      res_q;

	cell_ctl_t                 ctl   [DEPTH];
	logic signed [DATA_W-1:0]  cdata [DEPTH];
	logic [DEPTH-1:0]          cmatch;

	logic                      accept;
	logic [POS_W-1:0]          pos_m1;
	logic [IDX_W-1:0]          idx;
	logic                      ins_bad;
	logic                      acc_bad;
	logic                      is_full;
	logic                      ins_ok;
	logic                      del_ok;
	logic                      find_hit;
	logic [POS_W-1:0]          find_pos;
	logic [CNT_W-1:0]          fill_d;
	res_t                      res_d;

	assign req.ready = !rsp_valid_q || rsp.ready;
	assign accept    = req.valid && req.ready;

	assign pos_m1  = req.position - POS_W'(1);
	assign idx     = pos_m1[IDX_W-1:0];
	assign ins_bad = (req.position == '0) ||
		({1'b0, req.position} > ({1'b0, POS_W'(fill_q)} + (POS_W+1)'(1)));
	assign acc_bad = (req.position == '0) || (req.position > POS_W'(fill_q));
	assign is_full = (fill_q == CNT_W'(DEPTH));
	assign ins_ok  = accept && (req.cmd == CMD_INSERT) && !ins_bad && !is_full;
	assign del_ok  = accept && (req.cmd == CMD_DELETE) && !acc_bad;

	// per-cell move control, cell k sees its own place against position and fill
	for (genvar k = 0; k < DEPTH; k++) begin : g_cell
		logic signed [DATA_W-1:0] left_w;
		logic signed [DATA_W-1:0] right_w;

		always_comb begin
			ctl[k].wdata = req.item_value;
			ctl[k].key   = req.item_value;
			ctl[k].op    = CELL_HOLD;
			if (ins_ok) begin
				if (POS_W'(k) == pos_m1)
					ctl[k].op = CELL_LOAD;
				else if ((POS_W'(k) > pos_m1) && (CNT_W'(k) <= fill_q))
					ctl[k].op = CELL_LEFT;
			end else if (del_ok) begin
				if ((POS_W'(k) >= pos_m1) && ((CNT_W'(k) + CNT_W'(1)) < fill_q))
					ctl[k].op = CELL_RIGHT;
			end
		end

		if (k == 0) begin : g_first
			assign left_w = '0;
		end else begin : g_mid_l
			assign left_w = cdata[k-1];
		end
		if (k == DEPTH - 1) begin : g_last
			assign right_w = '0;
		end else begin : g_mid_r
			assign right_w = cdata[k+1];
		end

		pal_cell u_cell (
			.clk        (clk),
			.ctl        (ctl[k]),
			.left_data  (left_w),
			.right_data (right_w),
			.data       (cdata[k]),
			.match      (cmatch[k])
		);
	end

	// first live match wins
	always_comb begin
		find_hit = 1'b0;
		find_pos = '0;
		for (int k = DEPTH - 1; k >= 0; k--) begin
			if (cmatch[k] && (CNT_W'(k) < fill_q)) begin
				find_hit = 1'b1;
				find_pos = POS_W'(k + 1);
			end
		end
	end

	always_comb begin
		res_d  = '0;
		fill_d = fill_q;
		case (req.cmd)
			CMD_INSERT: begin
				if (ins_bad)
					res_d.status = ST_RANGE;
				else if (is_full)
					res_d.status = ST_FULL;
				else
					fill_d = fill_q + CNT_W'(1);
			end
			CMD_DELETE: begin
				if (acc_bad) begin
					res_d.status = ST_RANGE;
				end else begin
					res_d.read_value = cdata[idx];
					fill_d           = fill_q - CNT_W'(1);
				end
			end
			CMD_READ: begin
				if (acc_bad)
					res_d.status = ST_RANGE;
				else
					res_d.read_value = cdata[idx];
			end
			default: begin
				res_d.status         = find_hit ? ST_OK : ST_NOTFOUND;
				res_d.found_position = find_pos;
			end
		endcase
		res_d.count_after = POS_W'(fill_d);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q      <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				fill_q      <= fill_d;
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept)
			res_q <= res_d;
	end

	assign rsp.valid          = rsp_valid_q;
	assign rsp.status         = res_q.status;
	assign rsp.read_value     = res_q.read_value;
	assign rsp.found_position = res_q.found_position;
	assign rsp.count_after    = res_q.count_after;

	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= CNT_W'(DEPTH))
		else $error("fill count above depth");

	a_accept_gives_word: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> rsp_valid_q)
		else $error("accepted command gave no result word");

	a_count_tracks: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> (POS_W'(fill_q) == res_q.count_after))
		else $error("reported count differs from fill count");

	a_insert_grows: assert property (@(posedge clk) disable iff (!arst_n)
		ins_ok |=> (fill_q == $past(fill_q) + CNT_W'(1)))
		else $error("good insert did not grow the list");

	a_bad_keeps: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && !ins_ok && !del_ok) |=> $stable(fill_q))
		else $error("fill count moved on a command that changes nothing");

endmodule

// File: tb/positional_array_list_test.sv
// ----------------------------------------------------------------------------
// positional_array_list_test
// self-checking bench for the positional list: directed corner commands, then
// fill and drain sweeps with random content under random or no idling on both
// channels, and a long result stall that backs up the command channel
// ----------------------------------------------------------------------------
module positional_array_list_test;
	timeunit 1ns;
	timeprecision 1ps;

	import pal_pkg::*;

	localparam int CYCLE_LIMIT   = 400000;
	localparam int STALL_CYCLES  = 60;
	localparam int DRAIN_CYCLES  = 16;
	localparam int PRINT_CAP     = 100;
	localparam int RANDOM_ITEMS  = 370;

	logic clk;
	logic arst_n;

	pal_cmd_if req_ch ();
	pal_res_if rsp_ch ();

	positional_array_list u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch)
	);

	// shadow copy of the list
	logic signed [DATA_W-1:0] model_words [DEPTH];
	int                       model_len;

	res_t predicted_responses [$];

	int  mismatch_count;
	int  cycle_count;
	int  send_idle_pct;
	int  recv_idle_pct;
	bit  stall_active = 1'b0;
	bit  fill_mode;
	event stall_begin;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic res_t apply_list_command(input logic [CMD_W-1:0] cmd,
		input logic [POS_W-1:0] pos, input logic signed [DATA_W-1:0] val);
		res_t r;
		int   p;
		r = '0;
		r.status = ST_OK;
		p = pos;
		case (cmd)
			CMD_INSERT: begin
				// position check takes priority over the full check
				if (p < 1 || p > model_len + 1) begin
					r.status = ST_RANGE;
				end else if (model_len >= DEPTH) begin
					r.status = ST_FULL;
				end else begin
					for (int k = model_len; k >= p; k--)
						model_words[k] = model_words[k-1];
					model_words[p-1] = val;
					model_len++;
				end
			end
			CMD_DELETE: begin
				if (p < 1 || p > model_len) begin
					r.status = ST_RANGE;
				end else begin
					r.read_value = model_words[p-1];
					for (int k = p - 1; k + 1 < model_len; k++)
						model_words[k] = model_words[k+1];
					model_len--;
				end
			end
			CMD_READ: begin
				if (p < 1 || p > model_len)
					r.status = ST_RANGE;
				else
					r.read_value = model_words[p-1];
			end
			default: begin
				r.status = ST_NOTFOUND;
				for (int k = 0; k < model_len; k++) begin
					if (model_words[k] == val) begin
						r.found_position = POS_W'(k + 1);
						r.status = ST_OK;
						break;
					end
				end
			end
		endcase
		r.count_after = POS_W'(model_len);
		return r;
	endfunction

	task automatic report_mismatch(input string field, input logic [DATA_W-1:0] got,
		input logic [DATA_W-1:0] want);
		if (mismatch_count < PRINT_CAP)
			$display("mismatch at %0t: %s got %h expected %h", $realtime, field, got, want);
		mismatch_count++;
	endtask

	// result check first: a word accepted at this edge cannot be answered at it
	always @(posedge clk) begin
		res_t want;
		if (rsp_ch.valid && rsp_ch.ready) begin
			if (predicted_responses.size() == 0) begin
				report_mismatch("unexpected result word", DATA_W'(rsp_ch.status), '0);
			end else begin
				want = predicted_responses.pop_front();
				if (rsp_ch.status !== want.status)
					report_mismatch("status", DATA_W'(rsp_ch.status),
						DATA_W'(want.status));
				if (rsp_ch.read_value !== want.read_value)
					report_mismatch("read_value", rsp_ch.read_value, want.read_value);
				if (rsp_ch.found_position !== want.found_position)
					report_mismatch("found_position", DATA_W'(rsp_ch.found_position),
						DATA_W'(want.found_position));
				if (rsp_ch.count_after !== want.count_after)
					report_mismatch("count_after", DATA_W'(rsp_ch.count_after),
						DATA_W'(want.count_after));
			end
		end
		if (req_ch.valid && req_ch.ready)
			predicted_responses.push_back(apply_list_command(req_ch.cmd, req_ch.position,
				req_ch.item_value));
	end

	always @(negedge clk) begin
		if (stall_active)
			rsp_ch.ready <= 1'b0;
		else
			rsp_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
	end

	always begin
		@(stall_begin);
		@(posedge clk);
		stall_active = 1'b1;
		repeat (STALL_CYCLES) @(posedge clk);
		stall_active = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("FAILURE");
			$finish;
		end
	end

	task automatic send_command(input logic [CMD_W-1:0] cmd, input logic [POS_W-1:0] pos,
		input logic signed [DATA_W-1:0] val);
		while ($urandom_range(99) < send_idle_pct) begin
			req_ch.valid <= 1'b0;
			@(negedge clk);
		end
		req_ch.valid      <= 1'b1;
		req_ch.cmd        <= cmd;
		req_ch.position   <= pos;
		req_ch.item_value <= val;
		do @(posedge clk); while (!req_ch.ready);
		@(negedge clk);
	endtask

	function automatic logic signed [DATA_W-1:0] pick_value();
		case ($urandom_range(3))
			0: return DATA_W'($urandom_range(7));
			1: begin
				case ($urandom_range(3))
					0: return 32'sh7fffffff;
					1: return 32'sh80000000;
					2: return '0;
					default: return -32'sd1;
				endcase
			end
			default: return $urandom();
		endcase
	endfunction

	// sweeps between empty and full so that both ends get hit repeatedly
	task automatic send_random_command();
		logic [CMD_W-1:0]         cmd;
		logic [POS_W-1:0]         pos;
		logic signed [DATA_W-1:0] val;
		int                       roll;
		if (fill_mode && model_len == DEPTH && $urandom_range(3) == 0)
			fill_mode = 1'b0;
		else if (!fill_mode && model_len == 0 && $urandom_range(3) == 0)
			fill_mode = 1'b1;
		roll = $urandom_range(99);
		val  = pick_value();
		if (roll < 10) begin
			// noise: anything the fields allow
			cmd = CMD_W'($urandom_range(3));
			pos = POS_W'($urandom_range(31));
			val = $urandom();
		end else begin
			roll = $urandom_range(99);
			if (fill_mode)
				cmd = (roll < 65) ? CMD_INSERT : (roll < 75) ? CMD_DELETE :
					(roll < 88) ? CMD_READ : CMD_FIND;
			else
				cmd = (roll < 15) ? CMD_INSERT : (roll < 65) ? CMD_DELETE :
					(roll < 82) ? CMD_READ : CMD_FIND;
			case (cmd)
				CMD_INSERT: pos = POS_W'($urandom_range(model_len + 1, 1));
				CMD_FIND: begin
					pos = POS_W'($urandom_range(31));
					if (model_len > 0 && $urandom_range(9) < 6)
						val = model_words[$urandom_range(model_len - 1)];
				end
				default: begin
					if (model_len == 0)
						pos = POS_W'($urandom_range(1));
					else
						pos = POS_W'($urandom_range(model_len, 1));
					val = $urandom();
				end
			endcase
		end
		send_command(cmd, pos, val);
	endtask

	task automatic test_directed();
		send_idle_pct = 30;
		recv_idle_pct = 81;
		// empty list
		send_command(CMD_READ,   5'd1,  32'sd0);
		send_command(CMD_DELETE, 5'd1,  32'sd0);
		send_command(CMD_FIND,   5'd0,  32'sd0);
		send_command(CMD_INSERT, 5'd0,  32'sd9);
		send_command(CMD_INSERT, 5'd2,  32'sd9);
		// build -1, 5, max, min, 0
		send_command(CMD_INSERT, 5'd1,  32'sh7fffffff);
		send_command(CMD_INSERT, 5'd2,  32'sh80000000);
		send_command(CMD_INSERT, 5'd1,  -32'sd1);
		send_command(CMD_INSERT, 5'd4,  32'sd0);
		send_command(CMD_INSERT, 5'd2,  32'sd5);
		send_command(CMD_READ,   5'd1,  32'sh55555555);
		send_command(CMD_READ,   5'd5,  32'shaaaaaaaa);
		send_command(CMD_READ,   5'd6,  32'sd0);
		send_command(CMD_FIND,   5'd31, 32'sh80000000);
		send_command(CMD_FIND,   5'd0,  -32'sd1);
		send_command(CMD_FIND,   5'd0,  32'sd12345);
		send_command(CMD_INSERT, 5'd31, 32'sd0);
		send_command(CMD_DELETE, 5'd0,  32'sd0);
		// one past the length must be rejected
		send_command(CMD_DELETE, 5'd6,  32'sd0);
		send_command(CMD_DELETE, 5'd3,  32'sd0);
		send_command(CMD_DELETE, 5'd4,  32'sd0);
		send_command(CMD_DELETE, 5'd1,  32'sd0);
		send_command(CMD_READ,   5'd2,  32'sd0);
		// duplicate word, find reports the first
		send_command(CMD_INSERT, 5'd3,  32'sd5);
		send_command(CMD_FIND,   5'd17, 32'sd5);
	endtask

	task automatic test_random_sweep(input int sender_pct, input int receiver_pct);
		send_idle_pct = sender_pct;
		recv_idle_pct = receiver_pct;
		repeat (RANDOM_ITEMS) send_random_command();
	endtask

	task automatic test_result_stall();
		send_idle_pct = 0;
		recv_idle_pct = 0;
		-> stall_begin;
		repeat (30) send_random_command();
	endtask

	initial begin
		arst_n            = 1'b0;
		req_ch.valid      = 1'b0;
		req_ch.cmd        = CMD_INSERT;
		req_ch.position   = '0;
		req_ch.item_value = '0;
		rsp_ch.ready      = 1'b0;
		mismatch_count    = 0;
		cycle_count       = 0;
		model_len         = 0;
		fill_mode         = 1'b1;
		send_idle_pct     = 0;
		recv_idle_pct     = 0;
		foreach (model_words[i]) model_words[i] = '0;
		repeat (10) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		test_directed();
		test_random_sweep(30, 81);
		test_random_sweep(81, 30);
		test_random_sweep(0, 0);
		test_result_stall();

		req_ch.valid <= 1'b0;
		while (predicted_responses.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (predicted_responses.size() != 0)
			report_mismatch("results left over", predicted_responses.size(), '0);

		if (mismatch_count == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule

// File: sim.f
sv/pal_pkg.sv
sv/pal_cmd_if.sv
sv/pal_res_if.sv
sv/pal_cell.sv
sv/positional_array_list.sv
tb/positional_array_list_test.sv
